[sv/alu_register_execute_8bit_macros.svh]
// Assertion macros shared by the ALU execute block.
`ifndef ALU_REGISTER_EXECUTE_8BIT_MACROS_SVH
`define ALU_REGISTER_EXECUTE_8BIT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ARX_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("arx assertion failed");
// Condition must never be true outside reset.
`define ARX_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("arx forbidden condition seen");
`else
`define ARX_ASSERT(lbl, clk, rst, prop)
`define ARX_NEVER(lbl, clk, rst, cond)
`endif
`endif

[sv/arx_pkg.sv]
// Package: types, action codes and defaults for the 8-bit ALU execute block.
`default_nettype none

package arx_pkg;

   // Field widths
   localparam int ACT_W     = 5;
   localparam int REG_IDX_W = 4;
   localparam int DATA_W    = 8;

   // Defaults for top-level parameters
   localparam int NUM_REGS_DEF  = 16;
   localparam int MID_DEPTH_DEF = 2;
   localparam int OUT_DEPTH_DEF = 2;

   // Action codes on the request channel
   localparam logic [ACT_W-1:0] ACT_ADD  = 5'd0;
   localparam logic [ACT_W-1:0] ACT_ADDC = 5'd1;
   localparam logic [ACT_W-1:0] ACT_SUB  = 5'd2;
   localparam logic [ACT_W-1:0] ACT_SUBC = 5'd3;
   localparam logic [ACT_W-1:0] ACT_AND  = 5'd4;
   localparam logic [ACT_W-1:0] ACT_OR   = 5'd5;
   localparam logic [ACT_W-1:0] ACT_XOR  = 5'd6;
   localparam logic [ACT_W-1:0] ACT_NOT  = 5'd7;
   localparam logic [ACT_W-1:0] ACT_SHL  = 5'd8;
   localparam logic [ACT_W-1:0] ACT_SHR  = 5'd9;
   localparam logic [ACT_W-1:0] ACT_ROL  = 5'd10;
   localparam logic [ACT_W-1:0] ACT_ROR  = 5'd11;
   localparam logic [ACT_W-1:0] ACT_CMP  = 5'd12;
   localparam logic [ACT_W-1:0] ACT_TST  = 5'd13;
   localparam logic [ACT_W-1:0] ACT_MOV  = 5'd14;
   localparam logic [ACT_W-1:0] ACT_NEG  = 5'd15;
   localparam logic [ACT_W-1:0] ACT_LDI  = 5'd16;

   // Register index that a load-immediate may not target
   localparam logic [REG_IDX_W-1:0] ZERO_REG = 4'd0;

   // Internal operation classes after decode
   typedef enum logic [3:0] {
      ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC,
      ALU_AND, ALU_OR,  ALU_XOR, ALU_NOT,
      ALU_SHL, ALU_SHR, ALU_ROL, ALU_ROR,
      ALU_MOV, ALU_NEG, ALU_LDI, ALU_NOP
   } alu_op_type;

   typedef struct packed {
      logic [ACT_W-1:0]     action;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src_reg;
      logic [DATA_W-1:0]    immediate;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              reg_written;
      logic              zero_flag;
      logic              negative_flag;
      logic              carry_flag;
      logic              overflow_flag;
      logic              illegal;
   } rsp_payload_type;

   // Decoded operation passed from front to back
   typedef struct packed {
      alu_op_type           op;
      logic                 store;
      logic                 bad;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src_reg;
      logic [DATA_W-1:0]    immediate;
   } uop_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

endpackage

`default_nettype wire

[sv/arx_fifo.sv]
// Small register-based queue used between stages and at the result side.
`default_nettype none

module arx_fifo
   import arx_pkg::*;
#(
   parameter int DEPTH = MID_DEPTH_DEF,
   parameter int WIDTH = $bits(uop_type)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] data_in,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      data_out,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   // Status from the fill count
   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

[sv/arx_front.sv]
// Front end: accepts request transactions and classifies the action.
`default_nettype none

module arx_front
   import arx_pkg::*;
(
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire req_payload_type req_data,
   output logic                 uop_push,
   input  wire logic            uop_full,
   output uop_type              uop_data
);

   // Accept whenever the decoded queue has room
   assign req_full = uop_full;
   assign uop_push = req_push & ~uop_full;

   // Decode action into an operation class and write/illegal marks
   always_comb begin
      uop_data.op        = ALU_NOP;
      uop_data.store     = 1'b1;
      uop_data.bad       = 1'b0;
      uop_data.dest_reg  = req_data.dest_reg;
      uop_data.src_reg   = req_data.src_reg;
      uop_data.immediate = req_data.immediate;
      case (req_data.action)
         ACT_ADD:  uop_data.op = ALU_ADD;
         ACT_ADDC: uop_data.op = ALU_ADC;
         ACT_SUB:  uop_data.op = ALU_SUB;
         ACT_SUBC: uop_data.op = ALU_SBC;
         ACT_AND:  uop_data.op = ALU_AND;
         ACT_OR:   uop_data.op = ALU_OR;
         ACT_XOR:  uop_data.op = ALU_XOR;
         ACT_NOT:  uop_data.op = ALU_NOT;
         ACT_SHL:  uop_data.op = ALU_SHL;
         ACT_SHR:  uop_data.op = ALU_SHR;
         ACT_ROL:  uop_data.op = ALU_ROL;
         ACT_ROR:  uop_data.op = ALU_ROR;
         ACT_CMP: begin
            uop_data.op    = ALU_SUB;
            uop_data.store = 1'b0;
         end
         ACT_TST: begin
            uop_data.op    = ALU_AND;
            uop_data.store = 1'b0;
         end
         ACT_MOV:  uop_data.op = ALU_MOV;
         ACT_NEG:  uop_data.op = ALU_NEG;
         ACT_LDI: begin
            if (req_data.dest_reg == ZERO_REG) begin
               uop_data.store = 1'b0;
               uop_data.bad   = 1'b1;
            end else begin
               uop_data.op = ALU_LDI;
            end
         end
         default: begin
            uop_data.store = 1'b0;
            uop_data.bad   = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/arx_execute.sv]
// Back end: register read stage, ALU, flag update and register write-back.
`default_nettype none
`include "alu_register_execute_8bit_macros.svh"

module arx_execute
   import arx_pkg::*;
#(
   parameter int NUM_REGS = NUM_REGS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    uop_empty,
   output logic         uop_pop,
   input  wire uop_type uop_data,
   output logic         rsp_push,
   input  wire logic    rsp_full,
   output rsp_payload_type rsp_data
);

   localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam logic [REG_IDX_W:0] REG_LIMIT = (REG_IDX_W + 1)'(NUM_REGS);

   // Register file storage and per-entry written marks
   logic [DATA_W-1:0]   rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;

   // Read stage
   logic              r_vld_ff, r_vld_in;
   uop_type           r_uop_ff;
   logic [DATA_W-1:0] a_raw_ff, b_raw_ff;
   logic              a_ok_ff, b_ok_ff, a_ok_in, b_ok_in;
   logic              a_byp_ff, b_byp_ff, a_byp_in, b_byp_in;
   logic [DATA_W-1:0] byp_data_ff;

   flags_type         flags_ff, flags_in;

   logic              commit, load, we;
   logic [RIDX_W-1:0] widx, q_a_idx, q_b_idx;
   logic [DATA_W-1:0] a_val, b_val, opa, opb, res;
   logic              cin_add, zn_upd;
   logic [DATA_W:0]   sum;

   function automatic logic in_range(input logic [REG_IDX_W-1:0] idx);
      in_range = ({1'b0, idx} < REG_LIMIT);
   endfunction

   // Handshake between queue, read stage and result queue
   assign commit   = r_vld_ff & ~rsp_full;
   assign load     = (~r_vld_ff | commit) & ~uop_empty;
   assign uop_pop  = load;
   assign rsp_push = commit;
   assign r_vld_in = load | (r_vld_ff & ~commit);

   // Write-back control
   assign widx = r_uop_ff.dest_reg[RIDX_W-1:0];
   assign we   = commit & r_uop_ff.store & ~r_uop_ff.bad & in_range(r_uop_ff.dest_reg);

   // Read addresses and same-edge write bypass
   assign q_a_idx  = uop_data.dest_reg[RIDX_W-1:0];
   assign q_b_idx  = uop_data.src_reg[RIDX_W-1:0];
   assign a_ok_in  = in_range(uop_data.dest_reg) & rf_vld_ff[q_a_idx];
   assign b_ok_in  = in_range(uop_data.src_reg) & rf_vld_ff[q_b_idx];
   assign a_byp_in = we & (r_uop_ff.dest_reg == uop_data.dest_reg);
   assign b_byp_in = we & (r_uop_ff.dest_reg == uop_data.src_reg);

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff  <= 1'b0;
         rf_vld_ff <= '0;
         flags_ff  <= '0;
      end else begin
         r_vld_ff <= r_vld_in;
         flags_ff <= flags_in;
         if (we) begin
            rf_vld_ff[widx] <= 1'b1;
         end
      end
   end

   // Load the read stage; memory read data is registered here
   always_ff @(posedge clock) begin
      if (load) begin
         r_uop_ff    <= uop_data;
         a_raw_ff    <= rf_mem[q_a_idx];
         b_raw_ff    <= rf_mem[q_b_idx];
         a_ok_ff     <= a_ok_in;
         b_ok_ff     <= b_ok_in;
         a_byp_ff    <= a_byp_in;
         b_byp_ff    <= b_byp_in;
         byp_data_ff <= res;
      end
   end

   // Write back the result
   always_ff @(posedge clock) begin
      if (we) begin
         rf_mem[widx] <= res;
      end
   end

   // Select operands: bypass, stored value, or zero for unwritten/absent registers
   assign a_val = a_byp_ff ? byp_data_ff : (a_ok_ff ? a_raw_ff : '0);
   assign b_val = b_byp_ff ? byp_data_ff : (b_ok_ff ? b_raw_ff : '0);

   // Shared adder for add, subtract and negate
   always_comb begin
      opa     = a_val;
      opb     = b_val;
      cin_add = 1'b0;
      case (r_uop_ff.op)
         ALU_ADC: cin_add = flags_ff.c;
         ALU_SUB: begin
            opb     = ~b_val;
            cin_add = 1'b1;
         end
         ALU_SBC: begin
            opb     = ~b_val;
            cin_add = flags_ff.c;
         end
         ALU_NEG: begin
            opa     = '0;
            opb     = ~a_val;
            cin_add = 1'b1;
         end
         default: cin_add = 1'b0;
      endcase
      sum = {1'b0, opa} + {1'b0, opb} + {{DATA_W{1'b0}}, cin_add};
   end

   // Compute result and next flags
   always_comb begin
      res      = '0;
      zn_upd   = 1'b1;
      flags_in = flags_ff;
      case (r_uop_ff.op)
         ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC, ALU_NEG: begin
            res        = sum[DATA_W-1:0];
            flags_in.c = sum[DATA_W];
            flags_in.v = ~(opa[DATA_W-1] ^ opb[DATA_W-1]) & (opa[DATA_W-1] ^ res[DATA_W-1]);
         end
         ALU_AND: begin
            res        = a_val & b_val;
            flags_in.v = 1'b0;
         end
         ALU_OR: begin
            res        = a_val | b_val;
            flags_in.v = 1'b0;
         end
         ALU_XOR: begin
            res        = a_val ^ b_val;
            flags_in.v = 1'b0;
         end
         ALU_NOT: begin
            res        = ~b_val;
            flags_in.v = 1'b0;
         end
         ALU_SHL: begin
            res        = {b_val[DATA_W-2:0], 1'b0};
            flags_in.c = b_val[DATA_W-1];
            flags_in.v = 1'b0;
         end
         ALU_ROL: begin
            res        = {b_val[DATA_W-2:0], b_val[DATA_W-1]};
            flags_in.c = b_val[DATA_W-1];
            flags_in.v = 1'b0;
         end
         ALU_SHR: begin
            res        = {1'b0, b_val[DATA_W-1:1]};
            flags_in.c = b_val[0];
            flags_in.v = 1'b0;
         end
         ALU_ROR: begin
            res        = {b_val[0], b_val[DATA_W-1:1]};
            flags_in.c = b_val[0];
            flags_in.v = 1'b0;
         end
         ALU_MOV: res = b_val;
         ALU_LDI: begin
            res        = r_uop_ff.immediate;
            flags_in.v = 1'b0;
         end
         default: zn_upd = 1'b0;
      endcase
      if (zn_upd) begin
         flags_in.z = (res == '0);
         flags_in.n = res[DATA_W-1];
      end
      // Hold flags unless the transaction retires
      if (!commit) begin
         flags_in = flags_ff;
      end
   end

   // Build the result transaction
   always_comb begin
      rsp_data.result_value  = res;
      rsp_data.reg_written   = we;
      rsp_data.zero_flag     = flags_in.z;
      rsp_data.negative_flag = flags_in.n;
      rsp_data.carry_flag    = flags_in.c;
      rsp_data.overflow_flag = flags_in.v;
      rsp_data.illegal       = r_uop_ff.bad;
   end

   `ARX_ASSERT(a_stall_hold, clock, reset, (r_vld_ff && rsp_full) |=> (r_vld_ff && $stable(r_uop_ff)))
   `ARX_ASSERT(a_bad_keeps_flags, clock, reset, (commit && r_uop_ff.bad) |=> (flags_ff == $past(flags_ff)))
   `ARX_ASSERT(a_write_marks_entry, clock, reset, we |=> rf_vld_ff[$past(widx)])
   `ARX_NEVER(a_bad_result, clock, reset, r_vld_ff && r_uop_ff.bad && (we || rsp_data.result_value != '0))

endmodule

`default_nettype wire

[sv/alu_register_execute_8bit.sv]
// Use: 8-bit register-instruction execute block with NZCV flags.
// Request side is a queue write port: present req_data and raise req_push;
// the transaction is taken at a rising edge where req_push is high and
// req_full is low. Result side is a queue read port: while rsp_empty is low
// rsp_data holds the oldest result; raise rsp_pop to take it.
// Every request yields exactly one result, in order.
// A request passes through the decode queue, then the register read stage,
// then the ALU into the result queue before it shows on rsp_data.
// Throughput: one transaction per cycle while the result queue has room; the
// read stage reads the register file on each load, bypassing a same-edge write.
// When rsp_pop stays low the result queue fills, the read stage holds, the
// decode queue fills and req_full rises; no transaction is dropped.
// Reset (synchronous, active high) empties both queues, clears all flags and
// marks every register as zero; requests can be pushed in the next cycle.
`default_nettype none

module alu_register_execute_8bit
   import arx_pkg::*;
#(
   parameter int NUM_REGS  = NUM_REGS_DEF,
   parameter int MID_DEPTH = MID_DEPTH_DEF,
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire req_payload_type req_data,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output rsp_payload_type      rsp_data
);

   localparam int UOP_W = $bits(uop_type);
   localparam int RSP_W = $bits(rsp_payload_type);

   logic       uop_push, uop_full, uop_empty, uop_pop;
   uop_type    uop_wr, uop_rd;
   logic [UOP_W-1:0] uop_rd_bits;
   logic       res_push, res_full;
   rsp_payload_type  res_wr;
   logic [RSP_W-1:0] rsp_bits;

   // Decode incoming transactions
   arx_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .uop_push (uop_push),
      .uop_full (uop_full),
      .uop_data (uop_wr)
   );

   // Decouple decode from execution
   arx_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH (UOP_W)
   ) u_uop_q (
      .clock    (clock),
      .reset    (reset),
      .push     (uop_push),
      .data_in  (uop_wr),
      .full     (uop_full),
      .pop      (uop_pop),
      .data_out (uop_rd_bits),
      .empty    (uop_empty)
   );

   assign uop_rd = uop_rd_bits;

   // Execute against register file and flags
   arx_execute #(
      .NUM_REGS (NUM_REGS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .uop_empty (uop_empty),
      .uop_pop   (uop_pop),
      .uop_data  (uop_rd),
      .rsp_push  (res_push),
      .rsp_full  (res_full),
      .rsp_data  (res_wr)
   );

   // Hold results until the receiver pops them
   arx_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .data_in  (res_wr),
      .full     (res_full),
      .pop      (rsp_pop),
      .data_out (rsp_bits),
      .empty    (rsp_empty)
   );

   assign rsp_data = rsp_bits;

endmodule

`default_nettype wire
